// File: rtl/core/modbus_frame_unwrap_checker_unit_macros.svh
// Assertion macros shared by the RTL of the frame unwrap checker.
`ifndef MODBUS_FRAME_UNWRAP_CHECKER_UNIT_MACROS_SVH
`define MODBUS_FRAME_UNWRAP_CHECKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a plain condition on every clock edge outside reset.
`define MFUC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that the consequent holds in the same cycle as the antecedent.
`define MFUC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define MFUC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MFUC_ASSERT(lbl, expr, msg)
`define MFUC_ASSERT_IMP(lbl, ante, cons, msg)
`define MFUC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/core/mfuc_pkg.sv
package mfuc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;

  localparam int RTU_MIN_LEN   = 4;
  localparam int TCP_MIN_LEN   = 8;
  localparam int MBAP_HDR      = 6;
  localparam int TCP_PDU_START = 7;
  localparam int RTU_TRAILER   = 2;
  localparam int PDU_CAP       = 256;
  localparam int RTU_POS_LIMIT = PDU_CAP + 3;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_TRANSPORT_MODE = 1'b0;

  localparam logic MODE_RTU = 1'b0;
  localparam logic MODE_TCP = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_CRC_BAD   = 3'd2,
    ST_MBAP_BAD  = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       verdict;
    logic [7:0] unit_address;
    logic [8:0] pdu_length;
    status_t    status;
  } item_t;

  // One byte step of CRC-16/MODBUS, reflected.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/modbus_frame_unwrap_checker_unit.sv
// Channel | Direction | Handshake         | Word contents
// in      | input     | tvalid / tready   | rx_byte in tdata, end_of_frame in tlast
// out     | output    | tvalid / tready   | pdu_byte, unit_address, pdu_length,
//         |           |                   | status in tdata, verdict in tlast
// cfg     | input     | APB, pready high  | transport_mode at address 0
//
// One input word is taken per cycle in steady state; each word yields zero, one
// or two output words, which land in a three-entry output queue in the same cycle.
// The queue drains one word per cycle while the sink is ready, so a word that
// yields a PDU byte and the verdict holds off the next input word even when the
// sink keeps pace. in_tready is high while the queue holds at most one word:
// output stalls never reach back further than that.
// rst_n is synchronous, active low; it sets RTU mode and an empty frame.
`include "modbus_frame_unwrap_checker_unit_macros.svh"

module modbus_frame_unwrap_checker_unit #(
  parameter int MAX_FRAME_BYTES = mfuc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic                            in_tlast,   // end_of_frame
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] pdu_byte, [15:8] unit_address, [24:16] pdu_length, [27:25] status,
  // [31:28] zero
  output logic [31:0]                     out_tdata,
  output logic                            out_tlast,  // verdict
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mfuc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import mfuc_pkg::*;

  // Position counter must reach the larger of the size limit and the RTU limit.
  localparam int POS_MAX = (MAX_FRAME_BYTES > RTU_POS_LIMIT) ? MAX_FRAME_BYTES
                                                             : RTU_POS_LIMIT;
  localparam int POS_W   = $clog2(POS_MAX + 1);
  localparam int SUM_W   = 17;
  localparam int Q_DEPTH = 3;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic mode_r, mode_nxt;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && cfg_paddr[2] == REG_TRANSPORT_MODE) begin
      mode_nxt = cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_TRANSPORT_MODE) begin
      cfg_prdata = {31'd0, mode_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] pos_r,   pos_nxt;
  logic [15:0]      crc_r,   crc_nxt;
  logic [7:0]       older_r, older_nxt;
  logic [7:0]       newer_r, newer_nxt;
  logic [7:0]       unit_r,  unit_nxt;
  logic [15:0]      hlen_r,  hlen_nxt;
  logic             ovf_r,   ovf_nxt;

  logic             in_acc;
  logic             ovf_now;
  logic             emit_byte;
  logic [7:0]       emit_data;
  item_t            vitem;
  logic [POS_W:0]   rx_count;
  logic [15:0]      recv_crc;

  assign in_acc    = in_tvalid & in_tready;
  assign rx_count  = {1'b0, pos_r} + (POS_W+1)'(1);
  assign recv_crc  = {in_tdata, newer_r};

  // Overflow is judged on the arriving byte's position before any other step.
  always_comb begin
    ovf_now = ovf_r;
    if (pos_r >= POS_W'(MAX_FRAME_BYTES)) begin
      ovf_now = 1'b1;
    end
    if (mode_r == MODE_RTU && pos_r >= POS_W'(RTU_POS_LIMIT)) begin
      ovf_now = 1'b1;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    older_nxt = older_r;
    newer_nxt = newer_r;
    unit_nxt  = unit_r;
    hlen_nxt  = hlen_r;
    ovf_nxt   = ovf_r;
    emit_byte = 1'b0;
    emit_data = in_tdata;
    vitem     = '0;
    vitem.verdict = 1'b1;

    if (in_acc) begin
      ovf_nxt = ovf_now;
      if (mode_r == MODE_RTU) begin
        // Two-byte delay line holds back the CRC trailer.
        if (pos_r == '0) begin
          unit_nxt = in_tdata;
        end
        if (!ovf_now) begin
          if (pos_r >= POS_W'(2)) begin
            crc_nxt = crc16_step(crc_r, older_r);
          end
          if (pos_r >= POS_W'(3)) begin
            emit_byte = 1'b1;
            emit_data = older_r;
          end
        end
        older_nxt = newer_r;
        newer_nxt = in_tdata;
        if (ovf_now) begin
          vitem.status = ST_TOO_LONG;
        end else if (rx_count < (POS_W+1)'(RTU_MIN_LEN)) begin
          vitem.status = ST_TOO_SHORT;
        end else if (crc_nxt != recv_crc) begin
          vitem.status = ST_CRC_BAD;
        end else begin
          vitem.unit_address = unit_nxt;
          vitem.pdu_length   = 9'(pos_r - POS_W'(RTU_TRAILER));
        end
      end else begin
        // Capture the MBAP length (big endian) and the unit id.
        if (pos_r == POS_W'(4)) begin
          hlen_nxt[15:8] = in_tdata;
        end else if (pos_r == POS_W'(5)) begin
          hlen_nxt[7:0] = in_tdata;
        end else if (pos_r == POS_W'(6)) begin
          unit_nxt = in_tdata;
        end
        if (!ovf_now && pos_r >= POS_W'(TCP_PDU_START) &&
            hlen_nxt <= 16'(PDU_CAP + 1) &&
            SUM_W'(pos_r) < SUM_W'(hlen_nxt) + SUM_W'(MBAP_HDR)) begin
          emit_byte = 1'b1;
        end
        if (ovf_now) begin
          vitem.status = ST_TOO_LONG;
        end else if (rx_count < (POS_W+1)'(TCP_MIN_LEN)) begin
          vitem.status = ST_TOO_SHORT;
        end else if (hlen_nxt == '0 ||
                     SUM_W'(rx_count) < SUM_W'(hlen_nxt) + SUM_W'(MBAP_HDR)) begin
          vitem.status = ST_MBAP_BAD;
        end else if (hlen_nxt > 16'(PDU_CAP + 1)) begin
          vitem.status = ST_TOO_LONG;
        end else begin
          vitem.unit_address = unit_nxt;
          vitem.pdu_length   = 9'(hlen_nxt - 16'd1);
        end
      end

      if (in_tlast) begin
        // Drop all frame state once the verdict is out.
        pos_nxt   = '0;
        crc_nxt   = CRC_INIT;
        older_nxt = '0;
        newer_nxt = '0;
        unit_nxt  = '0;
        hlen_nxt  = '0;
        ovf_nxt   = 1'b0;
      end else if (!ovf_now) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end

    // A mode write restarts the frame.
    if (cfg_wr && cfg_paddr[2] == REG_TRANSPORT_MODE) begin
      pos_nxt   = '0;
      crc_nxt   = CRC_INIT;
      older_nxt = '0;
      newer_nxt = '0;
      unit_nxt  = '0;
      hlen_nxt  = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RTU;
      pos_r   <= '0;
      crc_r   <= CRC_INIT;
      older_r <= '0;
      newer_r <= '0;
      unit_r  <= '0;
      hlen_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      unit_r  <= unit_nxt;
      hlen_r  <= hlen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: slot 0 is the head, entries shift down on a pop.
  // ---------------------------------------------------------------------------
  item_t      q_r [Q_DEPTH];
  item_t      q_nxt [Q_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] push_n;
  logic [1:0] base;
  item_t      item_a, item_b;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid & out_tready;
  assign in_tready  = (cnt_r <= 2'd1);
  assign out_tdata  = {4'd0, q_r[0].status, q_r[0].pdu_length,
                       q_r[0].unit_address, q_r[0].pdu_byte};
  assign out_tlast  = q_r[0].verdict;

  always_comb begin
    item_a = vitem;
    item_b = vitem;
    push_n = 2'd0;
    if (in_acc) begin
      if (emit_byte) begin
        item_a          = '0;
        item_a.pdu_byte = emit_data;
        push_n          = in_tlast ? 2'd2 : 2'd1;
      end else begin
        push_n = in_tlast ? 2'd1 : 2'd0;
      end
    end
  end

  assign base    = cnt_r - {1'b0, pop};
  assign cnt_nxt = base + push_n;

  always_comb begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (push_n != 2'd0 && base == 2'(i)) begin
        q_nxt[i] = item_a;
      end
      if (push_n == 2'd2 && base + 2'd1 == 2'(i)) begin
        q_nxt[i] = item_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `MFUC_ASSERT_NXT(a_verdict_queued, in_acc && in_tlast, cnt_r != 2'd0, "verdict not queued")
  `MFUC_ASSERT_NXT(a_frame_cleared, in_acc && in_tlast, pos_r == '0 && !ovf_r, "frame not cleared")
  `MFUC_ASSERT_NXT(a_ovf_holds_pos, ovf_r && in_acc && !in_tlast && !cfg_wr, $stable(pos_r), "position moved after overflow")
  `MFUC_ASSERT(a_queue_bound, cnt_r <= 2'(Q_DEPTH), "output queue overrun")

endmodule

// File: verif/modbus_frame_unwrap_checker_unit_checker.sv
`timescale 1ns / 1ps

package mfuc_tb_pkg;

  localparam logic [15:0] CRC16_SEED      = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY_REFL = 16'hA001;

  // Advance a CRC-16/MODBUS by one byte, LSB first.
  function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module modbus_frame_unwrap_checker_unit_checker
  import mfuc_pkg::*;
  import mfuc_tb_pkg::*;
#(
  parameter int FRAME_MAX = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [31:0]           out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  input  logic [31:0]           cfg_prdata,
  input  logic                  cfg_pready,
  output int                    fail_count,
  output int                    words_due,
  output int                    words_checked
);

  localparam int REG_IDX_MODE  = 0;
  localparam int RTU_SHORTEST  = 4;
  localparam int TCP_SHORTEST  = 8;
  localparam int MBAP_BYTES    = 6;
  localparam int TCP_PDU_FIRST = 7;
  localparam int RTU_CRC_BYTES = 2;
  localparam int PDU_MAX       = 256;
  localparam int RTU_POS_STOP  = PDU_MAX + 3;

  typedef struct {
    logic [7:0] pdu_byte;
    logic       verdict;
    logic [7:0] unit_address;
    logic [8:0] pdu_length;
    status_t    status;
  } unwrap_word_t;

  unwrap_word_t unwrap_q[$];

  logic        xport_mode;
  int          frame_pos;
  logic [15:0] crc_acc;
  logic [7:0]  held_old;
  logic [7:0]  held_new;
  logic [7:0]  unit_id;
  logic [15:0] hdr_len;
  logic        too_long;

  function automatic unwrap_word_t make_word(input logic [7:0] pb, input logic vd,
                                             input logic [7:0] unit, input logic [8:0] plen,
                                             input status_t st);
    unwrap_word_t w;
    w.pdu_byte     = pb;
    w.verdict      = vd;
    w.unit_address = unit;
    w.pdu_length   = plen;
    w.status       = st;
    return w;
  endfunction

  task automatic clear_frame_state();
    frame_pos = 0;
    crc_acc   = CRC16_SEED;
    held_old  = '0;
    held_new  = '0;
    unit_id   = '0;
    hdr_len   = '0;
    too_long  = 1'b0;
  endtask

  // Predict the words that one received byte releases.
  task automatic unwrap_byte(input logic [7:0] b, input logic last);
    int          p;
    logic [15:0] trailer;
    logic [7:0]  v_unit;
    logic [8:0]  v_len;
    status_t     v_st;
    p      = frame_pos;
    v_unit = '0;
    v_len  = '0;
    v_st   = ST_OK;
    if (!too_long) begin
      if (p >= FRAME_MAX) too_long = 1'b1;
      if (xport_mode == MODE_RTU && p >= RTU_POS_STOP) too_long = 1'b1;
    end
    if (xport_mode == MODE_RTU) begin
      trailer = {b, held_new};
      if (p == 0) unit_id = b;
      if (!too_long) begin
        if (p >= 2) crc_acc = crc16_modbus(crc_acc, held_old);
        if (p >= 3) unwrap_q.push_back(make_word(held_old, 1'b0, '0, '0, ST_OK));
      end
      held_old = held_new;
      held_new = b;
      if (last) begin
        if (too_long) v_st = ST_TOO_LONG;
        else if (p + 1 < RTU_SHORTEST) v_st = ST_TOO_SHORT;
        else if (crc_acc != trailer) v_st = ST_CRC_BAD;
        else begin
          v_unit = unit_id;
          // frame length minus unit byte and CRC trailer
          v_len  = 9'(p + 1 - RTU_CRC_BYTES - 1);
        end
      end
    end else begin
      if (p == 4) hdr_len[15:8] = b;
      else if (p == 5) hdr_len[7:0] = b;
      else if (p == 6) unit_id = b;
      if (!too_long && p >= TCP_PDU_FIRST && int'(hdr_len) <= PDU_MAX + 1 &&
          p < int'(hdr_len) + MBAP_BYTES) begin
        unwrap_q.push_back(make_word(b, 1'b0, '0, '0, ST_OK));
      end
      if (last) begin
        if (too_long) v_st = ST_TOO_LONG;
        else if (p + 1 < TCP_SHORTEST) v_st = ST_TOO_SHORT;
        else if (hdr_len == 0 || p + 1 < int'(hdr_len) + MBAP_BYTES) v_st = ST_MBAP_BAD;
        else if (int'(hdr_len) > PDU_MAX + 1) v_st = ST_TOO_LONG;
        else begin
          v_unit = unit_id;
          v_len  = 9'(int'(hdr_len) - 1);
        end
      end
    end
    if (last) begin
      unwrap_q.push_back(make_word('0, 1'b1, v_unit, v_len, v_st));
      clear_frame_state();
    end else if (!too_long) begin
      frame_pos = p + 1;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    unwrap_word_t w;
    if (!rst_n) begin
      xport_mode = MODE_RTU;
      clear_frame_state();
      unwrap_q.delete();
      fail_count    = 0;
      words_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (unwrap_q.size() == 0) begin
          $error("unexpected result word: tdata 0x%08h tlast %0b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          w = unwrap_q.pop_front();
          check_field("pdu_byte", 32'(w.pdu_byte), 32'(out_tdata[7:0]));
          check_field("verdict", 32'(w.verdict), 32'(out_tlast));
          check_field("unit_address", 32'(w.unit_address), 32'(out_tdata[15:8]));
          check_field("pdu_length", 32'(w.pdu_length), 32'(out_tdata[24:16]));
          check_field("status", 32'(w.status), 32'(out_tdata[27:25]));
          check_field("tdata padding", 32'h0, 32'(out_tdata[31:28]));
          words_checked++;
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready && (cfg_paddr >> 2) == REG_IDX_MODE) begin
        if (cfg_pwrite) begin
          // a mode write abandons any frame in progress
          xport_mode = cfg_pwdata[0];
          clear_frame_state();
        end else begin
          check_field("transport_mode", {31'b0, xport_mode}, cfg_prdata);
        end
      end
      if (in_tvalid && in_tready) unwrap_byte(in_tdata, in_tlast);
    end
    words_due = unwrap_q.size();
  end

endmodule

// File: verif/tb_modbus_frame_unwrap_checker_unit.sv
`timescale 1ns / 1ps

module tb_modbus_frame_unwrap_checker_unit;
  import mfuc_pkg::*;
  import mfuc_tb_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int FRAME_MAX   = MAX_FRAME_BYTES_DEF;
  // cycles without any accepted word before the run is declared hung
  localparam int IDLE_LIMIT  = 4000;
  localparam int BYTES_PER_PROFILE = 165;
  localparam int RANDOM_FILL = -1;

  localparam logic [CFG_ADDR_W-1:0] ADDR_MODE     = 3'd0;
  // index 1: no register lives there
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
  localparam logic APB_WRITE = 1'b1;
  localparam logic APB_READ  = 1'b0;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata    = '0;   // [7:0] rx_byte
  logic                  in_tlast    = 1'b0; // end_of_frame
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  // [7:0] pdu_byte, [15:8] unit_address, [24:16] pdu_length, [27:25] status
  logic [31:0]           out_tdata;
  logic                  out_tlast;          // verdict
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int words_due;
  int words_checked;

  // handshake profiles: none, sender idle, receiver stall, both
  int src_profile[4] = '{0, 76, 0, 15};
  int snk_profile[4] = '{0, 0, 76, 15};
  int src_idle_pct   = 0;
  int snk_stall_pct  = 0;

  logic       xport_mode = MODE_RTU;  // last mode written
  logic [7:0] frame_buf[$];           // frame being assembled for transmission
  int         frames_rtu  = 0;
  int         frames_tcp  = 0;
  int         bytes_in    = 0;
  int         idle_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  modbus_frame_unwrap_checker_unit #(.MAX_FRAME_BYTES(FRAME_MAX)) DUT (.*);

  modbus_frame_unwrap_checker_unit_checker #(.FRAME_MAX(FRAME_MAX)) unwrap_chk (.*);

  // Sink: stall at random, redrawn every cycle.
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: count cycles in which no word moves on any port.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[modbus_frame_unwrap_checker_unit] ERROR");
      $finish;
    end
  end

  // Enter and leave at a falling edge. Leave tvalid high: the next call either
  // drives a new word or drops it before the coming rising edge.
  task automatic send_word(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    bytes_in++;
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = wr;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Hold off the sender until every predicted word has come out, then let
  // the block settle on any byte that released nothing.
  task automatic wait_all_results();
    in_tvalid = 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    wait_all_results();
    apb_access(APB_WRITE, ADDR_MODE, {31'b0, m});
    apb_access(APB_READ, ADDR_MODE, '0);
    xport_mode = m;
  endtask

  function automatic logic [7:0] pick(input int fill);
    return (fill < 0) ? 8'($urandom) : 8'(fill);
  endfunction

  // RTU frame: unit, PDU, CRC low byte then high byte.
  task automatic build_rtu(input int pdu_len, input int fill);
    logic [15:0] crc;
    frame_buf.delete();
    frame_buf.push_back(pick(fill));
    repeat (pdu_len) frame_buf.push_back(pick(fill));
    crc = CRC16_SEED;
    foreach (frame_buf[i]) crc = crc16_modbus(crc, frame_buf[i]);
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  // TCP frame: transaction and protocol ids, MBAP length, unit, PDU, trailing junk.
  task automatic build_tcp(input logic [15:0] hdr, input int pdu_len, input int extra,
                           input int fill);
    frame_buf.delete();
    repeat (4) frame_buf.push_back(8'($urandom));
    frame_buf.push_back(hdr[15:8]);
    frame_buf.push_back(hdr[7:0]);
    frame_buf.push_back(pick(fill));
    repeat (pdu_len) frame_buf.push_back(pick(fill));
    repeat (extra) frame_buf.push_back(8'($urandom));
  endtask

  task automatic build_noise(input int len);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
  endtask

  task automatic truncate(input int len);
    while (frame_buf.size() > len) void'(frame_buf.pop_back());
  endtask

  task automatic flip_bit(input int lo, input int hi);
    frame_buf[$urandom_range(hi, lo)] ^= 8'(1 << $urandom_range(7));
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_word(frame_buf[i], i == frame_buf.size() - 1);
    if (xport_mode == MODE_TCP) frames_tcp++;
    else frames_rtu++;
  endtask

  task automatic directed_frames();
    apb_access(APB_READ, ADDR_MODE, '0);
    // RTU: shortest good frame, all-zero and all-ones content
    build_rtu(1, 8'h00);
    send_frame();
    build_rtu(8, 8'hFF);
    send_frame();
    // RTU: too short at every length below the minimum
    for (int n = 1; n < 4; n++) begin
      build_noise(n);
      send_frame();
    end
    // RTU: corrupt the trailer
    build_rtu(4, RANDOM_FILL);
    flip_bit(frame_buf.size() - 2, frame_buf.size() - 1);
    send_frame();
    // RTU: longest frame that fits, then one byte over
    build_rtu(FRAME_MAX - 3, RANDOM_FILL);
    send_frame();
    build_rtu(FRAME_MAX - 2, RANDOM_FILL);
    send_frame();
    // abandon a frame halfway, then switch to TCP to restart it
    build_rtu(6, RANDOM_FILL);
    truncate(5);
    foreach (frame_buf[i]) send_word(frame_buf[i], 1'b0);
    set_mode(MODE_TCP);
    // TCP: shortest good frame; MBAP length 1 with a padding byte; trailing junk
    build_tcp(2, 1, 0, 8'h00);
    send_frame();
    build_tcp(1, 0, 1, 8'hFF);
    send_frame();
    build_tcp(6, 5, 3, RANDOM_FILL);
    send_frame();
    // TCP: too short
    build_tcp(2, 1, 0, RANDOM_FILL);
    truncate(7);
    send_frame();
    build_noise(1);
    send_frame();
    // TCP: MBAP length zero, frame shorter than its MBAP length, huge MBAP length
    build_tcp(0, 4, 0, RANDOM_FILL);
    send_frame();
    build_tcp(20, 5, 0, RANDOM_FILL);
    send_frame();
    build_tcp(16'hFFFF, 3, 0, RANDOM_FILL);
    send_frame();
    // TCP: longest frame that fits, then one byte over
    build_tcp(16'(FRAME_MAX - 6), FRAME_MAX - 7, 0, 8'hFF);
    send_frame();
    build_tcp(16'(FRAME_MAX - 5), FRAME_MAX - 6, 0, RANDOM_FILL);
    send_frame();
    // write a hole in the register map: mode must stay TCP
    wait_all_results();
    apb_access(APB_WRITE, ADDR_UNMAPPED, 32'h0);
    apb_access(APB_READ, ADDR_MODE, '0);
    build_tcp(4, 3, 0, RANDOM_FILL);
    send_frame();
    set_mode(MODE_RTU);
    build_rtu(3, RANDOM_FILL);
    send_frame();
  endtask

  // Mostly well-formed frames with random content; the rest corrupted,
  // truncated, oversized or plain noise. Few frames use the large sizes.
  task automatic random_frame();
    int k;
    int n;
    k = $urandom_range(99);
    if ($urandom_range(29) == 0) begin
      n = (xport_mode == MODE_RTU) ? $urandom_range(FRAME_MAX - 3, 60)
                                   : $urandom_range(FRAME_MAX - 7, 60);
    end else begin
      n = $urandom_range(16, 1);
    end
    if (xport_mode == MODE_RTU) begin
      if (k < 72) build_rtu(n, RANDOM_FILL);
      else if (k < 82) begin
        build_rtu(n, RANDOM_FILL);
        flip_bit(0, frame_buf.size() - 1);
      end
      else if (k < 88) build_noise($urandom_range(3, 1));
      else if (k < 92) build_noise($urandom_range(FRAME_MAX + 6, FRAME_MAX + 1));
      else build_noise($urandom_range(20, 4));
    end else begin
      if (k < 62) build_tcp(16'(n + 1), n, 0, RANDOM_FILL);
      else if (k < 72) build_tcp(16'(n + 1), n, $urandom_range(6, 1), RANDOM_FILL);
      else if (k < 80) begin
        build_tcp(16'(n + 1), n, 0, RANDOM_FILL);
        flip_bit(0, frame_buf.size() - 1);
      end
      else if (k < 86) begin
        build_tcp(16'(n + 1), n, 0, RANDOM_FILL);
        truncate($urandom_range(7, 1));
      end
      else if (k < 90) build_tcp(16'(n + 1 + $urandom_range(4, 1)), n, 0, RANDOM_FILL);
      else if (k < 93) begin
        build_tcp(($urandom_range(1) == 0) ? 16'h0 : 16'($urandom), n, 0, RANDOM_FILL);
      end
      else if (k < 96) build_noise($urandom_range(FRAME_MAX + 6, FRAME_MAX + 1));
      else build_noise($urandom_range(20, 1));
    end
    send_frame();
  endtask

  initial begin : stimulus
    int start_bytes;
    int frame_no;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_frames();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = src_profile[ph];
      snk_stall_pct = snk_profile[ph];
      start_bytes   = bytes_in;
      frame_no      = 0;
      while (bytes_in - start_bytes < BYTES_PER_PROFILE) begin
        random_frame();
        frame_no++;
        // every third frame write a random mode; else every fifth frame pause the sender until drained
        if (frame_no % 3 == 0) set_mode(1'($urandom_range(1)));
        else if (frame_no % 5 == 0) wait_all_results();
      end
    end

    wait_all_results();
    repeat (10) @(posedge clk);
    $display("Covered %0d RTU and %0d TCP frames, %0d bytes in, %0d result words compared",
             frames_rtu, frames_tcp, bytes_in, words_checked);
    $display("across four handshake profiles, with mode writes and drain pauses between frames.");
    if (fail_count == 0) begin
      $display("[modbus_frame_unwrap_checker_unit] OK");
    end else begin
      $display("[modbus_frame_unwrap_checker_unit] ERROR");
    end
    $finish;
  end

endmodule
